// ===== hw/rtl/arrsort_pkg.sv =====
// Shared types, constants and the ordering compare for the batch sorter.
package arrsort_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// Controls broadcast from the sequencer to every cell
	typedef struct packed {
		logic ins;   // insert the incoming value into the chain
		logic pop;   // shift the chain toward the head by one
		logic desc;  // largest first when set
	} ctl_t;

	// True when b must come before a in the selected order
	function automatic logic ahead(input data_t b, input data_t a, input logic desc);
		logic res;
		if (desc) begin
			res = b > a;
		end else begin
			res = b < a;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/arrsort_cell.sv =====
// One cell of the insertion chain: holds one element and trades with its neighbors.
module arrsort_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arrsort_pkg::ctl_t    ctl,
	input  arrsort_pkg::data_t   new_val,
	input  arrsort_pkg::data_t   left_val,
	input  logic                 left_vld,
	input  logic                 left_take,
	input  arrsort_pkg::data_t   right_val,
	input  logic                 right_vld,
	output arrsort_pkg::data_t   val,
	output logic                 vld,
	output logic                 take
);

	arrsort_pkg::data_t val_q;
	logic               vld_q;

	// The new value belongs at or before this slot
	assign take = !vld_q || arrsort_pkg::ahead(new_val, val_q, ctl.desc);
	assign val  = val_q;
	assign vld  = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.pop) begin
			vld_q <= right_vld;
		end else if (ctl.ins && take) begin
			vld_q <= left_take ? left_vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			val_q <= right_val;
		end else if (ctl.ins && take) begin
			// shift right if the slot on the left also moves, else take the new value
			val_q <= left_take ? left_val : new_val;
		end
	end

endmodule

// ===== hw/rtl/arrsort_ctrl.sv =====
// Sequencer: load and drain phases, overflow tracking and the output register.
module arrsort_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 last_item,
	input  logic                 desc,
	input  logic                 full,
	input  logic                 head_vld_next,
	input  arrsort_pkg::data_t   head_val,
	output arrsort_pkg::ctl_t    ctl,
	output logic                 out_valid,
	input  logic                 out_stall,
	output arrsort_pkg::data_t   sorted_value,
	output logic                 last_result,
	output logic                 overflow_dropped
);

	arrsort_pkg::state_t state_q, state_d;
	logic               ovf_seen_q;
	logic               out_valid_q;
	logic               last_q;
	logic               ovf_q;
	arrsort_pkg::data_t sorted_q;
	logic               in_xfer;
	logic               final_pop;

	assign in_xfer   = in_valid && !in_stall;
	assign final_pop = ctl.pop && !head_vld_next;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b0;
		ctl.ins  = 1'b0;
		ctl.pop  = 1'b0;
		ctl.desc = desc;
		unique case (state_q)
			arrsort_pkg::ST_LOAD: begin
				// drop the value when the chain is full
				ctl.ins = in_valid && !full;
				if (in_valid && last_item) begin
					state_d = arrsort_pkg::ST_DRAIN;
				end
			end
			arrsort_pkg::ST_DRAIN: begin
				in_stall = 1'b1;
				ctl.pop  = !out_valid_q || !out_stall;
				if (ctl.pop && !head_vld_next) begin
					state_d = arrsort_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = arrsort_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arrsort_pkg::ST_LOAD;
			ovf_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && full) begin
				ovf_seen_q <= 1'b1;
			end else if (final_pop) begin
				ovf_seen_q <= 1'b0;
			end
			if (ctl.pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			sorted_q <= head_val;
			last_q   <= !head_vld_next;
			ovf_q    <= !head_vld_next && ovf_seen_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign sorted_value     = sorted_q;
	assign last_result      = last_q;
	assign overflow_dropped = ovf_q;

endmodule

// ===== hw/rtl/array_sort_asc_desc_top.sv =====
// Top level of the batch sorter: mode register, sequencer and the insertion chain.
//
//  channel | signals                                         | moves
//  --------+-------------------------------------------------+----------------------
//  input   | in_valid, in_stall, item_value, last_item       | one element
//  output  | out_valid, out_stall, sorted_value, last_result, | one sorted element
//          | overflow_dropped                                |
//  config  | cfg_we, cfg_wdata                               | descending_order bit
//
// Loading takes one element per cycle; each transfer is inserted in place by the chain unless it is full.
// After the last element of a batch the input stalls while the chain shifts out
// one result per cycle when the output is not stalled.
// An output stall holds the chain; the input reopens as the final result is registered.
// Reset empties the chain at once; element storage itself is not cleared.
module array_sort_asc_desc_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  arrsort_pkg::data_t   item_value,
	input  logic                 last_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output arrsort_pkg::data_t   sorted_value,
	output logic                 last_result,
	output logic                 overflow_dropped
);

	localparam int N = arrsort_pkg::MAX_ITEMS;

	logic               desc_q;
	arrsort_pkg::ctl_t  ctl;
	arrsort_pkg::data_t val_w  [N];
	logic               vld_w  [N];
	logic               take_w [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_we) begin
			desc_q <= cfg_wdata;
		end
	end

	arrsort_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.last_item        (last_item),
		.desc             (desc_q),
		.full             (vld_w[N-1]),
		.head_vld_next    (vld_w[1]),
		.head_val         (val_w[0]),
		.ctl              (ctl),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sorted_value     (sorted_value),
		.last_result      (last_result),
		.overflow_dropped (overflow_dropped)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		arrsort_pkg::data_t l_val;
		logic               l_vld;
		logic               l_take;
		arrsort_pkg::data_t r_val;
		logic               r_vld;

		if (i == 0) begin : g_head
			assign l_val  = item_value;
			assign l_vld  = 1'b1;
			assign l_take = 1'b0;
		end else begin : g_mid
			assign l_val  = val_w[i-1];
			assign l_vld  = vld_w[i-1];
			assign l_take = take_w[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_next
			assign r_val = val_w[i+1];
			assign r_vld = vld_w[i+1];
		end

		arrsort_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_val   (item_value),
			.left_val  (l_val),
			.left_vld  (l_vld),
			.left_take (l_take),
			.right_val (r_val),
			.right_vld (r_vld),
			.val       (val_w[i]),
			.vld       (vld_w[i]),
			.take      (take_w[i])
		);
	end

endmodule

// ===== hw/rtl/arrsort_checker.sv =====
// Port-level checks for the batch sorter, bound to the top level.
module arrsort_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 last_item,
	input logic                 out_valid,
	input logic                 out_stall,
	input arrsort_pkg::data_t   sorted_value,
	input logic                 last_result,
	input logic                 overflow_dropped
);

	// Overflow is reported only on the final result of a batch
	a_ovf_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_dropped |-> last_result)
		else $error("overflow flag on a non-final result");

	// Ending a batch closes the input until the drain is done
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_item |=> in_stall)
		else $error("input open right after the last element");

	// A pending non-final result means the batch is still draining
	a_stall_mid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> in_stall)
		else $error("input open while a batch is still draining");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value)
			&& $stable(last_result) && $stable(overflow_dropped))
		else $error("stalled result changed");

endmodule

bind array_sort_asc_desc_top arrsort_checker u_arrsort_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.last_item        (last_item),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.sorted_value     (sorted_value),
	.last_result      (last_result),
	.overflow_dropped (overflow_dropped)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the batch sorter: directed table, then random batches.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS  = 20;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		arrsort_pkg::data_t value;
		logic               last;
		logic               dropped;
	} sorted_res_t;

	typedef struct {
		arrsort_pkg::data_t value;
		logic               last;
		logic               fixed;       // expected result typed in below
		arrsort_pkg::data_t exp_value;
		logic               exp_last;
		logic               exp_dropped;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	arrsort_pkg::data_t item_value;
	logic               last_item;
	logic               out_valid;
	logic               out_stall;
	arrsort_pkg::data_t sorted_value;
	logic               last_result;
	logic               overflow_dropped;

	// Predictor state
	arrsort_pkg::data_t batch_vals[$];
	logic               batch_dropped;
	logic               mode_desc;
	sorted_res_t        pending_sorted[$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;
	int cycle_count;

	localparam int DIR_ROWS = 11;
	stim_row_t dir_tab[DIR_ROWS] = '{
		'{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b1, 1'b0},
		'{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff, 1'b1, 1'b0},
		'{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000, 1'b1, 1'b0},
		'{32'shffff_ffff, 1'b1, 1'b1, 32'shffff_ffff, 1'b1, 1'b0},
		'{32'sh0000_0005, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
		'{32'shffff_fffd, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
		'{32'sh7fff_ffff, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
		'{32'sh8000_0000, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
		'{32'sh0000_0000, 1'b1, 1'b0, 32'sh0, 1'b0, 1'b0},
		'{32'sh0000_0007, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
		'{32'sh0000_0007, 1'b1, 1'b0, 32'sh0, 1'b0, 1'b0}
	};

	array_sort_asc_desc_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.item_value       (item_value),
		.last_item        (last_item),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sorted_value     (sorted_value),
		.last_result      (last_result),
		.overflow_dropped (overflow_dropped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Store one element; on the last mark, sort the batch and queue its results.
	task automatic sort_batch(input arrsort_pkg::data_t v, input logic last,
			input logic use_fixed, input sorted_res_t fixed_res);
		arrsort_pkg::data_t ordered[$];
		arrsort_pkg::data_t tmp;
		sorted_res_t        res;
		if (batch_vals.size() < arrsort_pkg::MAX_ITEMS) begin
			batch_vals.push_back(v);
		end else begin
			batch_dropped = 1'b1;
		end
		if (last) begin
			ordered = batch_vals;
			for (int i = 0; i < ordered.size(); i++) begin
				for (int j = i + 1; j < ordered.size(); j++) begin
					if (mode_desc ? (ordered[j] > ordered[i]) : (ordered[j] < ordered[i])) begin
						tmp        = ordered[i];
						ordered[i] = ordered[j];
						ordered[j] = tmp;
					end
				end
			end
			if (use_fixed) begin
				pending_sorted.push_back(fixed_res);
			end else begin
				for (int k = 0; k < ordered.size(); k++) begin
					res.value   = ordered[k];
					res.last    = (k == ordered.size() - 1);
					res.dropped = res.last ? batch_dropped : 1'b0;
					pending_sorted.push_back(res);
				end
			end
			batch_vals.delete();
			batch_dropped = 1'b0;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input arrsort_pkg::data_t v, input logic last,
			input logic use_fixed, input sorted_res_t fixed_res);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		item_value <= v;
		last_item  <= last;
		do begin
			@(posedge clk);
		end while (in_stall);
		sort_batch(v, last, use_fixed, fixed_res);
		@(negedge clk);
	endtask

	// Hold the input until every queued result has arrived, then let the block settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_sorted.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic desc);
		cfg_we    <= 1'b1;
		cfg_wdata <= desc;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mode_desc = desc;
		@(negedge clk);
	endtask

	function automatic arrsort_pkg::data_t pick_value();
		arrsort_pkg::data_t v;
		case ($urandom_range(0, 5))
			0: v = 32'sh8000_0000;
			1: v = 32'sh7fff_ffff;
			2, 3: v = arrsort_pkg::data_t'(int'($urandom_range(0, 8)) - 4);
			default: v = arrsort_pkg::data_t'($urandom);
		endcase
		return v;
	endfunction

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		sorted_res_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sorted.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result: value %0d last %0b dropped %0b",
						sorted_value, last_result, overflow_dropped);
			end else begin
				exp_res = pending_sorted.pop_front();
				if (sorted_value !== exp_res.value || last_result !== exp_res.last ||
						overflow_dropped !== exp_res.dropped) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							exp_res.value, exp_res.last, exp_res.dropped,
							sorted_value, last_result, overflow_dropped);
				end
			end
		end
	end

	initial begin
		sorted_res_t fixed_res;
		int          sent;
		int          len;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 1'b0;
		in_valid       = 1'b0;
		item_value     = '0;
		last_item      = 1'b0;
		out_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		batch_dropped  = 1'b0;
		mode_desc      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table, once per sort direction
		for (int m = 0; m < 2; m++) begin
			write_mode(m[0]);
			foreach (dir_tab[r]) begin
				fixed_res.value   = dir_tab[r].exp_value;
				fixed_res.last    = dir_tab[r].exp_last;
				fixed_res.dropped = dir_tab[r].exp_dropped;
				send_item(dir_tab[r].value, dir_tab[r].last, dir_tab[r].fixed, fixed_res);
			end
			drain_results();
		end

		// Random batches; some overrun the store to exercise the drop flag
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			write_mode(phase[0]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(62, 68)
					: $urandom_range(1, 10);
				for (int k = 0; k < len; k++)
					send_item(pick_value(), k == len - 1, 1'b0, fixed_res);
				sent += len;
				if ($urandom_range(0, 7) == 0)
					drain_results();
			end
			drain_results();
		end

		if (mismatch_count == 0 && pending_sorted.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
